[sv/ckpb_pkg.sv]
// ckpb_pkg: shared types, codes and helper functions for the chroma-key palette blitter
// no dependencies; imported by every module of the block but ckpb_ram

package ckpb_pkg;

	// palette geometry
	localparam int PAL_ENTRIES = 256;
	localparam int PAL_IDX_W   = $clog2(PAL_ENTRIES);
	localparam int PAL_WORD_W  = 32;

	// transparent source index
	localparam logic [7:0] KEY_INDEX = 8'hff;

	// item kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	// pixel formats
	localparam logic [1:0] MODE_IDX8   = 2'd0;
	localparam logic [1:0] MODE_RGB555 = 2'd1;
	localparam logic [1:0] MODE_RGB565 = 2'd2;
	localparam logic [1:0] MODE_RGB32  = 2'd3;

	// register indexes (byte address / 4)
	localparam int         APB_ADDR_W = 5;
	localparam logic [2:0] REG_DEPTH  = 3'd0;
	localparam logic [2:0] REG_BASE   = 3'd1;
	localparam logic [2:0] REG_PITCH  = 3'd2;
	localparam logic [2:0] REG_ORG_X  = 3'd3;
	localparam logic [2:0] REG_ORG_Y  = 3'd4;

	// input item
	typedef struct packed {
		logic        kind;
		logic [7:0]  entry_index;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  mapped_index;
		logic [7:0]  pixel_index;
		logic [11:0] col;
		logic [11:0] row;
	} in_item_t;

	// result item
	typedef struct packed {
		logic        write_enable;
		logic [31:0] write_address;
		logic [31:0] write_data;
		logic [2:0]  byte_count;
	} out_item_t;

	// configuration register contents
	typedef struct packed {
		logic [1:0]  depth_mode;
		logic [31:0] frame_base;
		logic [13:0] row_pitch;
		logic [11:0] origin_x;
		logic [11:0] origin_y;
	} cfg_t;

	// bytes per pixel for a format
	function automatic logic [2:0] bytes_for_mode(input logic [1:0] mode);
		logic [2:0] n;
		case (mode)
			MODE_IDX8:  n = 3'd1;
			MODE_RGB32: n = 3'd4;
			default:    n = 3'd2;
		endcase
		return n;
	endfunction

	// data mask for a format
	function automatic logic [31:0] mask_for_mode(input logic [1:0] mode);
		logic [31:0] m;
		case (mode)
			MODE_IDX8:  m = 32'h0000_00ff;
			MODE_RGB32: m = 32'hffff_ffff;
			default:    m = 32'h0000_ffff;
		endcase
		return m;
	endfunction

	// colour conversion for a palette load
	function automatic logic [31:0] convert_colour(
		input logic [1:0] mode,
		input logic [7:0] r,
		input logic [7:0] g,
		input logic [7:0] b,
		input logic [7:0] mapped
	);
		logic [31:0] w;
		case (mode)
			MODE_IDX8:   w = {24'd0, mapped};
			MODE_RGB555: w = {17'd0, r[7:3], g[7:3], b[7:3]};
			MODE_RGB565: w = {16'd0, r[7:3], g[7:2], b[7:3]};
			default:     w = {8'd0, b, g, r};
		endcase
		return w;
	endfunction

endpackage

[sv/chroma_key_palette_blitter.sv]
// chroma_key_palette_blitter: top level, handshake pipeline and output register
// depends on ckpb_pkg, ckpb_regs, ckpb_palette, ckpb_addr
//
//  channel   direction  handshake                    payload
//  src       in         src_valid / src_stall        src_item (in_item_t)
//  dst       out        dst_valid / dst_stall        dst_item (out_item_t)
//  apb       in/out     psel, penable, pready        paddr, pwdata, prdata
//
// one item per clock sustained while dst_stall is low; a pixel result passes the
// input register at the transfer, palette read and row multiply, output register
// palette loads retire in the cycle after transfer and give no result
// reset clears control state, configuration registers and all palette valid bits at once
// each stage holds a pixel while the stage after it is full and stalled; loads never hold

module chroma_key_palette_blitter import ckpb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	output logic                  src_stall,
	input  in_item_t              src_item,
	output logic                  dst_valid,
	input  logic                  dst_stall,
	output out_item_t             dst_item,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	cfg_t        cfg;
	logic        v_s1;
	in_item_t    item_s1;
	logic        v_s2;
	logic        key_s2;
	logic        dst_valid_q;
	out_item_t   dst_item_q;
	logic        s1_is_pix;
	logic        s1_go;
	logic        s1_free;
	logic        s2_free;
	logic        out_free;
	logic        src_xfer;
	logic        pal_wr;
	logic        pal_rd;
	logic [31:0] pal_word;
	logic [31:0] addr_s2;
	out_item_t   res_s2;

	ckpb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// stage flow control
	assign out_free  = !dst_valid_q || !dst_stall;
	assign s2_free   = !v_s2 || out_free;
	assign s1_is_pix = item_s1.kind == KIND_PIXEL;
	assign s1_go     = v_s1 && (!s1_is_pix || s2_free);
	assign s1_free   = !v_s1 || s1_go;
	assign src_stall = !s1_free;
	assign src_xfer  = src_valid && s1_free;
	assign pal_wr    = v_s1 && !s1_is_pix;
	assign pal_rd    = v_s1 && s1_is_pix && s2_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_xfer) begin
			item_s1 <= src_item;
		end
	end

	ckpb_palette u_palette (
		.clk        (clk),
		.arst_n     (arst_n),
		.depth_mode (cfg.depth_mode),
		.wr_en      (pal_wr),
		.wr_slot    (item_s1.entry_index),
		.wr_red     (item_s1.red),
		.wr_green   (item_s1.green),
		.wr_blue    (item_s1.blue),
		.wr_mapped  (item_s1.mapped_index),
		.rd_en      (pal_rd),
		.rd_index   (item_s1.pixel_index),
		.rd_word    (pal_word)
	);

	ckpb_addr u_addr (
		.clk  (clk),
		.en   (pal_rd),
		.cfg  (cfg),
		.col  (item_s1.col),
		.row  (item_s1.row),
		.addr (addr_s2)
	);

	// second stage: pixel flags alongside the palette read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= v_s1 && s1_is_pix;
		end
	end

	always_ff @(posedge clk) begin
		if (pal_rd) begin
			key_s2 <= item_s1.pixel_index == KEY_INDEX;
		end
	end

	// result assembly
	always_comb begin
		res_s2.write_enable  = !key_s2;
		res_s2.write_address = addr_s2;
		res_s2.write_data    = pal_word & mask_for_mode(cfg.depth_mode);
		res_s2.byte_count    = bytes_for_mode(cfg.depth_mode);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid_q <= 1'b0;
		end else if (out_free) begin
			dst_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s2) begin
			dst_item_q <= res_s2;
		end
	end

	assign dst_valid = dst_valid_q;
	assign dst_item  = dst_item_q;

	// back-pressure toward the source only comes from a pixel waiting in stage one
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> (v_s1 && s1_is_pix && v_s2 && dst_valid_q && dst_stall))
		else $error("source stalled without a blocked pixel");

	// a pixel leaving stage two shows up at the output
	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && s2_free) |=> dst_valid)
		else $error("pixel lost between stage two and output");

	// byte count is always a legal size
	a_byte_count: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid |-> (dst_item.byte_count == 3'd1 || dst_item.byte_count == 3'd2
			|| dst_item.byte_count == 3'd4))
		else $error("illegal byte count");

endmodule

[sv/ckpb_ram.sv]
// ckpb_ram: generic simple dual-port RAM, one write port and one registered read port
// no dependencies

module ckpb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[sv/ckpb_regs.sv]
// ckpb_regs: APB-style configuration registers of the blitter
// depends on ckpb_pkg

module ckpb_regs import ckpb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t       cfg_q;
	logic       wr_go;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_go   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	// register writes on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_go) begin
			case (reg_idx)
				REG_DEPTH: cfg_q.depth_mode <= pwdata[1:0];
				REG_BASE:  cfg_q.frame_base <= pwdata;
				REG_PITCH: cfg_q.row_pitch  <= pwdata[13:0];
				REG_ORG_X: cfg_q.origin_x   <= pwdata[11:0];
				REG_ORG_Y: cfg_q.origin_y   <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	// read-back mux
	always_comb begin
		case (reg_idx)
			REG_DEPTH: prdata = {30'd0, cfg_q.depth_mode};
			REG_BASE:  prdata = cfg_q.frame_base;
			REG_PITCH: prdata = {18'd0, cfg_q.row_pitch};
			REG_ORG_X: prdata = {20'd0, cfg_q.origin_x};
			REG_ORG_Y: prdata = {20'd0, cfg_q.origin_y};
			default:   prdata = 32'd0;
		endcase
	end

endmodule

[sv/ckpb_palette.sv]
// ckpb_palette: translated palette store with per-entry valid bits and colour conversion
// depends on ckpb_pkg and ckpb_ram

module ckpb_palette import ckpb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [1:0]            depth_mode,
	input  logic                  wr_en,
	input  logic [7:0]            wr_slot,
	input  logic [7:0]            wr_red,
	input  logic [7:0]            wr_green,
	input  logic [7:0]            wr_blue,
	input  logic [7:0]            wr_mapped,
	input  logic                  rd_en,
	input  logic [7:0]            rd_index,
	output logic [PAL_WORD_W-1:0] rd_word
);

	logic [PAL_ENTRIES-1:0] valid_q;
	logic                   rd_hit_q;
	logic                   wr_in_range;
	logic                   rd_in_range;
	logic                   wr_go;
	logic [PAL_IDX_W-1:0]   wr_idx;
	logic [PAL_IDX_W-1:0]   rd_idx;
	logic [PAL_WORD_W-1:0]  wr_word;
	logic [PAL_WORD_W-1:0]  ram_word;

	// slot range checks; out-of-range loads are dropped, reads give zero
	assign wr_in_range = {1'b0, wr_slot} < 9'(PAL_ENTRIES);
	assign rd_in_range = {1'b0, rd_index} < 9'(PAL_ENTRIES);
	assign wr_idx      = wr_slot[PAL_IDX_W-1:0];
	assign rd_idx      = rd_index[PAL_IDX_W-1:0];
	assign wr_go       = wr_en && wr_in_range;
	assign wr_word     = convert_colour(depth_mode, wr_red, wr_green, wr_blue, wr_mapped);

	ckpb_ram #(
		.WIDTH (PAL_WORD_W),
		.DEPTH (PAL_ENTRIES)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_go),
		.wr_addr (wr_idx),
		.wr_data (wr_word),
		.rd_en   (rd_en),
		.rd_addr (rd_idx),
		.rd_data (ram_word)
	);

	// entry valid bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_go) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	// hit flag follows the registered read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_hit_q <= 1'b0;
		end else if (rd_en) begin
			rd_hit_q <= rd_in_range && valid_q[rd_idx];
		end
	end

	assign rd_word = rd_hit_q ? ram_word : '0;

	// one item occupies the read side at a time, so no read collides with a write
	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !rd_en)
		else $error("palette read and write in the same cycle");

endmodule

[sv/ckpb_addr.sv]
// ckpb_addr: two-stage framebuffer address generator (row multiply, then final sum)
// depends on ckpb_pkg

module ckpb_addr import ckpb_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  cfg_t        cfg,
	input  logic [11:0] col,
	input  logic [11:0] row,
	output logic [31:0] addr
);

	logic [12:0] ypos;
	logic [12:0] xpos;
	logic [26:0] prod;
	logic [14:0] xoff;
	logic [26:0] prod_s2;
	logic [14:0] xoff_s2;

	// destination row times pitch; column scaled by bytes per pixel
	assign ypos = {1'b0, row} + {1'b0, cfg.origin_y};
	assign xpos = {1'b0, col} + {1'b0, cfg.origin_x};
	assign prod = {14'd0, ypos} * {13'd0, cfg.row_pitch};

	always_comb begin
		case (cfg.depth_mode)
			MODE_IDX8:  xoff = {2'b00, xpos};
			MODE_RGB32: xoff = {xpos, 2'b00};
			default:    xoff = {1'b0, xpos, 1'b0};
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= prod;
			xoff_s2 <= xoff;
		end
	end

	// final sum, wraps modulo 2^32
	assign addr = cfg.frame_base + {5'd0, prod_s2} + {17'd0, xoff_s2};

endmodule

[dv/testbench.sv]
// testbench for chroma_key_palette_blitter: directed table, then randomised phases under idling
// depends on ckpb_pkg and the blitter rtl; expected writes come from a local palette predictor or typed table rows

module testbench;
	import ckpb_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 80;
	localparam int DRAIN_CYCLES   = 8;
	localparam int ITEM_W         = $bits(in_item_t);

	typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_DST, IDLE_BOTH} idle_mode_t;

	// one row of the directed table
	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  src_valid;
	logic                  src_stall;
	in_item_t              src_item;
	logic                  dst_valid;
	logic                  dst_stall;
	out_item_t             dst_item;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	// predictor state
	logic [31:0] palette_shadow [PAL_ENTRIES];
	cfg_t        cfg_shadow;
	out_item_t   expected_writes [$];

	int errors;
	int n_loads;
	int n_pixels;
	int n_keyed;
	int n_checked;
	int gap_pct;
	int stall_pct;
	bit quiet;
	int idle_cycles;

	logic [1:0] mode_seq [PHASES] = '{MODE_RGB32, MODE_RGB555, MODE_RGB565, MODE_IDX8,
		MODE_RGB555, MODE_RGB32, MODE_IDX8, MODE_RGB565};

	chroma_key_palette_blitter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_item  (dst_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// clock, period 20
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	task automatic flag_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch %s: got %h, expected %h (write %0d)", what, got, want, n_checked);
		errors++;
	endtask

	// palette translation and write address prediction for one accepted item
	function automatic void blit_predict(input in_item_t it, input bit typed,
		input out_item_t typed_write);
		logic [2:0]  nbytes;
		logic [31:0] mask;
		logic [31:0] word;
		out_item_t   w;
		if (it.kind == KIND_LOAD) begin
			case (cfg_shadow.depth_mode)
				MODE_IDX8:   word = 32'(it.mapped_index);
				MODE_RGB555: word = ((32'(it.red) >> 3) << 10) | ((32'(it.green) >> 3) << 5)
					| (32'(it.blue) >> 3);
				MODE_RGB565: word = ((32'(it.red) >> 3) << 11) | ((32'(it.green) >> 2) << 5)
					| (32'(it.blue) >> 3);
				default:     word = 32'(it.red) | (32'(it.green) << 8) | (32'(it.blue) << 16);
			endcase
			palette_shadow[it.entry_index] = word;
			n_loads++;
			return;
		end
		if (cfg_shadow.depth_mode == MODE_IDX8)
			nbytes = 3'd1;
		else if (cfg_shadow.depth_mode == MODE_RGB32)
			nbytes = 3'd4;
		else
			nbytes = 3'd2;
		mask = (nbytes == 3'd4) ? 32'hffff_ffff : ((32'd1 << (8 * nbytes)) - 32'd1);
		w.write_enable  = (it.pixel_index != KEY_INDEX);
		w.write_address = cfg_shadow.frame_base
			+ (32'(it.row) + 32'(cfg_shadow.origin_y)) * 32'(cfg_shadow.row_pitch)
			+ 32'(nbytes) * (32'(it.col) + 32'(cfg_shadow.origin_x));
		w.write_data    = palette_shadow[it.pixel_index] & mask;
		w.byte_count    = nbytes;
		n_pixels++;
		if (!w.write_enable)
			n_keyed++;
		expected_writes.push_back(typed ? typed_write : w);
	endfunction

	function automatic in_item_t pix(input logic [7:0] idx, input logic [11:0] c,
		input logic [11:0] r);
		in_item_t it;
		it             = '0;
		it.kind        = KIND_PIXEL;
		it.pixel_index = idx;
		it.col         = c;
		it.row         = r;
		return it;
	endfunction

	function automatic in_item_t pal_load(input logic [7:0] slot, input logic [7:0] r,
		input logic [7:0] g, input logic [7:0] b, input logic [7:0] mapped);
		in_item_t it;
		it              = '0;
		it.kind         = KIND_LOAD;
		it.entry_index  = slot;
		it.red          = r;
		it.green        = g;
		it.blue         = b;
		it.mapped_index = mapped;
		return it;
	endfunction

	// random item: mostly pixels, some keyed, positions biased to the edges now and then
	function automatic in_item_t random_item();
		in_item_t it;
		it              = ITEM_W'({$urandom, $urandom, $urandom});
		it.kind         = ($urandom_range(99) < 30) ? KIND_LOAD : KIND_PIXEL;
		if ($urandom_range(9) == 0)
			it.pixel_index = KEY_INDEX;
		if ($urandom_range(9) == 0)
			it.col = $urandom_range(1) ? 12'hfff : 12'h000;
		if ($urandom_range(9) == 0)
			it.row = $urandom_range(1) ? 12'hfff : 12'h000;
		return it;
	endfunction

	// one source transfer, with random gaps before it
	task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
		@(negedge clk);
		while (!quiet && gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			src_valid = 1'b0;
			src_item  = ITEM_W'({$urandom, $urandom, $urandom});
			@(negedge clk);
		end
		src_valid = 1'b1;
		src_item  = it;
		do
			@(posedge clk);
		while (src_stall);
		blit_predict(it, typed, want);
	endtask

	// register write, then read back
	task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
		logic [31:0] stored;
		case (idx)
			REG_DEPTH: stored = value & 32'h3;
			REG_BASE:  stored = value;
			REG_PITCH: stored = value & 32'h3fff;
			REG_ORG_X: stored = value & 32'hfff;
			default:   stored = value & 32'hfff;
		endcase
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			REG_DEPTH: cfg_shadow.depth_mode = stored[1:0];
			REG_BASE:  cfg_shadow.frame_base = stored;
			REG_PITCH: cfg_shadow.row_pitch  = stored[13:0];
			REG_ORG_X: cfg_shadow.origin_x   = stored[11:0];
			default:   cfg_shadow.origin_y   = stored[11:0];
		endcase
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		pwdata  = $urandom;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== stored)
			flag_mismatch("register read-back", prdata, stored);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// receiver stalls
	always @(negedge clk) begin
		dst_stall <= (!quiet && stall_pct != 0 && $urandom_range(99) < stall_pct);
	end

	// result checking against the oldest expected write
	always @(posedge clk) begin : check_writes
		out_item_t want;
		if (arst_n && dst_valid && !dst_stall) begin
			if (expected_writes.size() == 0) begin
				flag_mismatch("unexpected write, address", dst_item.write_address, '0);
			end else begin
				want = expected_writes.pop_front();
				if (dst_item.write_enable !== want.write_enable)
					flag_mismatch("write_enable", 32'(dst_item.write_enable),
						32'(want.write_enable));
				if (dst_item.write_address !== want.write_address)
					flag_mismatch("write_address", dst_item.write_address, want.write_address);
				if (dst_item.write_data !== want.write_data)
					flag_mismatch("write_data", dst_item.write_data, want.write_data);
				if (dst_item.byte_count !== want.byte_count)
					flag_mismatch("byte_count", 32'(dst_item.byte_count), 32'(want.byte_count));
			end
			n_checked++;
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((src_valid && !src_stall) || (dst_valid && !dst_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d writes outstanding",
				idle_cycles, expected_writes.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		stim_row_t  directed_rows [$];
		idle_mode_t idle;
		int         phase;
		int         n;
		logic [31:0] base;
		logic [31:0] pitch;
		logic [31:0] org_x;
		logic [31:0] org_y;

		// known values everywhere before reset
		arst_n      = 1'b0;
		src_valid   = 1'b0;
		src_item    = '0;
		dst_stall   = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		errors      = 0;
		n_loads     = 0;
		n_pixels    = 0;
		n_keyed     = 0;
		n_checked   = 0;
		gap_pct     = 0;
		stall_pct   = 0;
		quiet       = 1'b0;
		idle_cycles = 0;
		cfg_shadow  = '0;
		foreach (palette_shadow[i])
			palette_shadow[i] = '0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table at reset settings: 8-bit indexed, zero base, pitch and origin
		directed_rows.push_back(stim_row_t'{pix(8'h00, 12'h000, 12'h000), 1'b1,
			out_item_t'{1'b1, 32'h0000_0000, 32'h0, 3'd1}});
		directed_rows.push_back(stim_row_t'{pix(KEY_INDEX, 12'hfff, 12'hfff), 1'b1,
			out_item_t'{1'b0, 32'h0000_0fff, 32'h0, 3'd1}});
		directed_rows.push_back(stim_row_t'{pix(8'h80, 12'h800, 12'h7ff), 1'b1,
			out_item_t'{1'b1, 32'h0000_0800, 32'h0, 3'd1}});
		directed_rows.push_back(stim_row_t'{pal_load(8'h00, 8'hff, 8'hff, 8'hff, 8'hff),
			1'b0, '0});
		directed_rows.push_back(stim_row_t'{pal_load(KEY_INDEX, 8'h00, 8'h00, 8'h00, 8'haa),
			1'b0, '0});
		directed_rows.push_back(stim_row_t'{pal_load(8'h01, 8'h80, 8'h7f, 8'h01, 8'h00),
			1'b0, '0});
		directed_rows.push_back(stim_row_t'{pal_load(8'hfe, 8'h12, 8'h34, 8'h56, 8'h7e),
			1'b0, '0});
		directed_rows.push_back(stim_row_t'{pal_load(8'h00, 8'h00, 8'h00, 8'h00, 8'h81),
			1'b0, '0});
		directed_rows.push_back(stim_row_t'{pix(8'h00, 12'h000, 12'h000), 1'b0, '0});
		directed_rows.push_back(stim_row_t'{pix(KEY_INDEX, 12'h000, 12'h000), 1'b0, '0});
		directed_rows.push_back(stim_row_t'{pix(8'h01, 12'hfff, 12'h000), 1'b0, '0});
		directed_rows.push_back(stim_row_t'{pix(8'hfe, 12'h001, 12'hfff), 1'b0, '0});
		directed_rows.push_back(stim_row_t'{pix(8'h02, 12'h555, 12'haaa), 1'b0, '0});
		directed_rows.push_back(stim_row_t'{pal_load(8'h02, 8'h55, 8'haa, 8'h55, 8'h55),
			1'b0, '0});
		directed_rows.push_back(stim_row_t'{pix(8'h02, 12'haaa, 12'h555), 1'b0, '0});
		directed_rows.push_back(stim_row_t'{pix(KEY_INDEX, 12'hfff, 12'hfff), 1'b0, '0});
		foreach (directed_rows[i])
			send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

		// randomised phases, each with its own settings and idling
		for (phase = 0; phase < PHASES; phase++) begin
			// drain before touching the registers
			@(negedge clk);
			src_valid = 1'b0;
			while (expected_writes.size() != 0)
				@(negedge clk);
			repeat (DRAIN_CYCLES) @(negedge clk);
			quiet     = 1'b0;
			gap_pct   = 0;
			stall_pct = 0;

			if (phase == 0) begin
				base  = 32'hffff_ffff;
				pitch = 32'h3fff;
				org_x = 32'hfff;
				org_y = 32'hfff;
			end else if (phase == 1) begin
				base  = 32'h0;
				pitch = 32'h0;
				org_x = 32'h0;
				org_y = 32'h0;
			end else begin
				base  = $urandom;
				pitch = $urandom_range(16383);
				org_x = $urandom_range(4095);
				org_y = $urandom_range(4095);
			end
			write_register(REG_DEPTH, {30'd0, mode_seq[phase]});
			write_register(REG_BASE, base);
			write_register(REG_PITCH, pitch);
			write_register(REG_ORG_X, org_x);
			write_register(REG_ORG_Y, org_y);

			idle = idle_mode_t'(phase % 4);
			case (idle)
				IDLE_SRC:  gap_pct = 87;
				IDLE_DST:  stall_pct = 87;
				IDLE_BOTH: begin
					gap_pct   = 31;
					stall_pct = 31;
				end
				default:   gap_pct = 0;
			endcase

			for (n = 0; n < PHASE_ITEMS; n++) begin
				// short stretches with no idling
				quiet = ((n % 20) >= 16);
				// mid-phase hold-off until every write is out
				if (n == PHASE_ITEMS / 2) begin
					@(negedge clk);
					src_valid = 1'b0;
					while (expected_writes.size() != 0)
						@(negedge clk);
				end
				send_item(random_item(), 1'b0, '0);
			end
		end

		// wait for the last writes, then a few more cycles for anything stray
		@(negedge clk);
		src_valid = 1'b0;
		while (expected_writes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d palette loads and %0d pixels (%0d keyed), %0d writes checked",
			n_loads, n_pixels, n_keyed, n_checked);
		$display("over %0d register settings in all four pixel formats, with gaps and stalls",
			PHASES);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
